### src/bucket_sort_engine_core_defines.svh
// assertion macros for the bucket sort engine core
// used by the top level only; expects clk and arst_n in scope
`ifndef BUCKET_SORT_ENGINE_CORE_DEFINES_SVH
`define BUCKET_SORT_ENGINE_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BSE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define BSE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/bse_pkg.sv
// shared types, constants and helpers for the bucket sort engine core
// no dependencies; used by bse_tag_unit and bucket_sort_engine_core
`default_nettype none

package bse_pkg;

	localparam int VAL_W           = 32;
	localparam int TAG_W           = 6;
	localparam int NB_W            = 7;
	localparam int QUO_W           = 7;
	localparam int REM_W           = VAL_W + QUO_W - 1;
	localparam int MAX_ITEMS_DEF   = 64;
	localparam int MAX_BUCKETS_DEF = 64;
	localparam logic [NB_W-1:0] BUCKET_COUNT_RST = NB_W'(10);
	localparam logic signed [VAL_W-1:0] VAL_MOST_POS = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] VAL_MOST_NEG = {1'b1, {(VAL_W-1){1'b0}}};

	// input beat
	typedef struct packed {
		logic signed [VAL_W-1:0] sample;
		logic                    is_last;
	} bse_in_t;

	// output beat
	typedef struct packed {
		logic signed [VAL_W-1:0] sorted_value;
		logic                    last_out;
	} bse_out_t;

	// one store entry: bucket tag beside its value
	typedef struct packed {
		logic [TAG_W-1:0]        tag;
		logic signed [VAL_W-1:0] value;
	} bse_entry_t;

	// request into the tagging unit
	typedef struct packed {
		logic                    start;
		logic signed [VAL_W-1:0] value;
		logic signed [VAL_W-1:0] lo;
		logic signed [VAL_W-1:0] hi;
		logic [NB_W-1:0]         nb;
	} bse_tag_req_t;

	// response from the tagging unit
	typedef struct packed {
		logic             done;
		logic [TAG_W-1:0] tag;
	} bse_tag_rsp_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TAG_RD,
		ST_TAG_GO,
		ST_TAG_DIV,
		ST_SORT_RD,
		ST_SORT_KEY,
		ST_SORT_CMP,
		ST_SORT_PUT,
		ST_EMIT_RD,
		ST_EMIT_WAIT
	} bse_state_t;

	// order by bucket first, then by value
	function automatic logic goes_after(input bse_entry_t a, input bse_entry_t b);
		logic res;
		if (a.tag != b.tag) begin
			res = (a.tag > b.tag);
		end else begin
			res = (a.value > b.value);
		end
		return res;
	endfunction

endpackage

`default_nettype wire

### src/bse_tag_unit.sv
// bucket tagging unit: (v - min) * nb / (max - min), floored, minus one, clamped at zero
// a registered multiply on start, then a restoring divide with one compare-subtract per cycle
// depends on bse_pkg
`default_nettype none

module bse_tag_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bse_pkg::bse_tag_req_t req,
	output bse_pkg::bse_tag_rsp_t  rsp
);

	localparam int STEP_W = $clog2(bse_pkg::QUO_W);

	logic                           busy_q;
	logic                           done_q;
	logic [STEP_W-1:0]              step_q;
	logic [bse_pkg::REM_W-1:0]      rem_q;
	logic [bse_pkg::REM_W-1:0]      dsh_q;
	logic [bse_pkg::QUO_W-1:0]      quo_q;
	logic                           zero_q;

	logic [bse_pkg::VAL_W-1:0]      diff;
	logic [bse_pkg::VAL_W-1:0]      range;
	logic                           ge;
	logic [bse_pkg::QUO_W-1:0]      quo_dec;

	// operands; both differences are non-negative and below 2^32
	assign diff    = bse_pkg::VAL_W'(req.value - req.lo);
	assign range   = bse_pkg::VAL_W'(req.hi - req.lo);
	assign ge      = (rem_q >= dsh_q);
	assign quo_dec = quo_q - bse_pkg::QUO_W'(1);

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(bse_pkg::QUO_W - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - STEP_W'(1);
				end
			end
		end
	end

	// multiply on start, then one quotient bit per cycle, msb first
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= bse_pkg::REM_W'(diff) * bse_pkg::REM_W'(req.nb);
			dsh_q  <= {range, (bse_pkg::QUO_W-1)'(0)};
			quo_q  <= '0;
			zero_q <= (req.hi <= req.lo);
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[bse_pkg::QUO_W-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	// quotient never exceeds nb, so the decrement always fits a tag
	always_comb begin
		rsp.done = done_q;
		if (zero_q || quo_q == '0) begin
			rsp.tag = '0;
		end else begin
			rsp.tag = quo_dec[bse_pkg::TAG_W-1:0];
		end
	end

endmodule

`default_nettype wire

### src/bucket_sort_engine_core.sv
// bucket sort engine core. a non-last beat is taken while idle; a last beat starts the sort.
// tagging: per stored value a read, a multiply and 7 divide steps in the shared unit.
// sorting: insertion by bucket then value over the one-read, one-write-port value store.
// emit: each result is read, then held valid until out_ready; no input beat is taken until done.
// reset (arst_n low) clears count, extremes, sequencer and sets bucket_count to 10;
// the value store is not cleared, only entries written in the current set are read.
`default_nettype none
`include "bucket_sort_engine_core_defines.svh"

module bucket_sort_engine_core #(
	parameter int MAX_ITEMS   = bse_pkg::MAX_ITEMS_DEF,
	parameter int MAX_BUCKETS = bse_pkg::MAX_BUCKETS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire bse_pkg::bse_in_t          in_data,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output bse_pkg::bse_out_t              out_data,
	input  wire logic                      cfg_we,
	input  wire logic [bse_pkg::NB_W-1:0]  cfg_wdata
);

	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW = $clog2(MAX_ITEMS + 1);

	bse_pkg::bse_state_t state_q, state_nx;

	logic [bse_pkg::NB_W-1:0]           bucket_count_q;
	logic [bse_pkg::NB_W-1:0]           nb_eff;
	logic [CW-1:0]                      count_q;
	logic [CW-1:0]                      idx_q;
	logic [CW-1:0]                      jdx_q;
	logic [CW-1:0]                      idx_inc;
	logic [CW-1:0]                      jdx_m1;
	logic [CW-1:0]                      jdx_m2;
	logic signed [bse_pkg::VAL_W-1:0]   min_q;
	logic signed [bse_pkg::VAL_W-1:0]   max_q;
	bse_pkg::bse_entry_t                key_q;
	bse_pkg::bse_entry_t                rd_data_q;
	bse_pkg::bse_entry_t                mem [MAX_ITEMS];

	logic                               rd_en;
	logic [AW-1:0]                      rd_addr;
	logic                               wr_en;
	logic [AW-1:0]                      wr_addr;
	bse_pkg::bse_entry_t                wr_data;

	logic                               in_beat;
	logic                               store_ok;
	logic                               tag_last;
	logic                               set_last;
	logic                               after;
	logic                               tag_start;
	bse_pkg::bse_tag_req_t              tag_req;
	bse_pkg::bse_tag_rsp_t              tag_rsp;

	assign idx_inc  = idx_q + CW'(1);
	assign jdx_m1   = jdx_q - CW'(1);
	assign jdx_m2   = jdx_q - CW'(2);
	assign in_beat  = in_valid && in_ready;
	assign store_ok = (count_q < CW'(MAX_ITEMS));
	assign tag_last = (idx_inc == count_q);
	assign set_last = (idx_inc == count_q);
	assign after    = bse_pkg::goes_after(rd_data_q, key_q);

	// zero buckets act as one, too many saturate
	always_comb begin
		if (bucket_count_q == '0) begin
			nb_eff = bse_pkg::NB_W'(1);
		end else if (bucket_count_q > bse_pkg::NB_W'(MAX_BUCKETS)) begin
			nb_eff = bse_pkg::NB_W'(MAX_BUCKETS);
		end else begin
			nb_eff = bucket_count_q;
		end
	end

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= bse_pkg::BUCKET_COUNT_RST;
		end else if (cfg_we) begin
			bucket_count_q <= cfg_wdata;
		end
	end

	// shared tagging unit
	assign tag_req.start = tag_start;
	assign tag_req.value = rd_data_q.value;
	assign tag_req.lo    = min_q;
	assign tag_req.hi    = max_q;
	assign tag_req.nb    = nb_eff;

	bse_tag_unit u_tag (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (tag_req),
		.rsp    (tag_rsp)
	);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			bse_pkg::ST_IDLE: begin
				if (in_beat && in_data.is_last) begin
					state_nx = bse_pkg::ST_TAG_RD;
				end
			end
			bse_pkg::ST_TAG_RD:  state_nx = bse_pkg::ST_TAG_GO;
			bse_pkg::ST_TAG_GO:  state_nx = bse_pkg::ST_TAG_DIV;
			bse_pkg::ST_TAG_DIV: begin
				if (tag_rsp.done) begin
					if (!tag_last) begin
						state_nx = bse_pkg::ST_TAG_RD;
					end else if (count_q == CW'(1)) begin
						state_nx = bse_pkg::ST_EMIT_RD;
					end else begin
						state_nx = bse_pkg::ST_SORT_RD;
					end
				end
			end
			bse_pkg::ST_SORT_RD:  state_nx = bse_pkg::ST_SORT_KEY;
			bse_pkg::ST_SORT_KEY: state_nx = bse_pkg::ST_SORT_CMP;
			bse_pkg::ST_SORT_CMP: begin
				if (!after || jdx_q == CW'(1)) begin
					state_nx = bse_pkg::ST_SORT_PUT;
				end
			end
			bse_pkg::ST_SORT_PUT: begin
				state_nx = set_last ? bse_pkg::ST_EMIT_RD : bse_pkg::ST_SORT_RD;
			end
			bse_pkg::ST_EMIT_RD: state_nx = bse_pkg::ST_EMIT_WAIT;
			bse_pkg::ST_EMIT_WAIT: begin
				if (out_ready) begin
					state_nx = set_last ? bse_pkg::ST_IDLE : bse_pkg::ST_EMIT_RD;
				end
			end
			default: state_nx = bse_pkg::ST_IDLE;
		endcase
	end

	// memory ports, unit start and handshakes per state
	always_comb begin
		in_ready      = 1'b0;
		out_valid     = 1'b0;
		tag_start     = 1'b0;
		rd_en         = 1'b0;
		rd_addr       = idx_q[AW-1:0];
		wr_en         = 1'b0;
		wr_addr       = idx_q[AW-1:0];
		wr_data       = key_q;
		case (state_q)
			bse_pkg::ST_IDLE: begin
				in_ready      = 1'b1;
				wr_en         = in_valid && store_ok;
				wr_addr       = count_q[AW-1:0];
				wr_data.tag   = '0;
				wr_data.value = in_data.sample;
			end
			bse_pkg::ST_TAG_RD: begin
				rd_en = 1'b1;
			end
			bse_pkg::ST_TAG_GO: begin
				tag_start = 1'b1;
			end
			bse_pkg::ST_TAG_DIV: begin
				wr_en         = tag_rsp.done;
				wr_data.tag   = tag_rsp.tag;
				wr_data.value = rd_data_q.value;
			end
			bse_pkg::ST_SORT_RD: begin
				rd_en = 1'b1;
			end
			bse_pkg::ST_SORT_KEY: begin
				rd_en   = 1'b1;
				rd_addr = jdx_m1[AW-1:0];
			end
			bse_pkg::ST_SORT_CMP: begin
				// shift the larger neighbor up and look one further down
				wr_addr = jdx_q[AW-1:0];
				wr_data = rd_data_q;
				rd_addr = jdx_m2[AW-1:0];
				if (after) begin
					wr_en = 1'b1;
					rd_en = (jdx_q != CW'(1));
				end
			end
			bse_pkg::ST_SORT_PUT: begin
				wr_en   = 1'b1;
				wr_addr = jdx_q[AW-1:0];
			end
			bse_pkg::ST_EMIT_RD: begin
				rd_en = 1'b1;
			end
			bse_pkg::ST_EMIT_WAIT: begin
				out_valid = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// result beat straight from the held read register
	assign out_data.sorted_value = rd_data_q.value;
	assign out_data.last_out     = set_last;

	// value store, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// sort key
	always_ff @(posedge clk) begin
		if (state_q == bse_pkg::ST_SORT_KEY) begin
			key_q <= rd_data_q;
		end
	end

	// sequencer and set bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bse_pkg::ST_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			jdx_q   <= '0;
			min_q   <= bse_pkg::VAL_MOST_POS;
			max_q   <= bse_pkg::VAL_MOST_NEG;
		end else begin
			state_q <= state_nx;
			case (state_q)
				bse_pkg::ST_IDLE: begin
					if (in_beat && store_ok) begin
						count_q <= count_q + CW'(1);
						if (in_data.sample < min_q) begin
							min_q <= in_data.sample;
						end
						if (in_data.sample > max_q) begin
							max_q <= in_data.sample;
						end
					end
				end
				bse_pkg::ST_TAG_DIV: begin
					if (tag_rsp.done) begin
						if (!tag_last) begin
							idx_q <= idx_inc;
						end else if (count_q == CW'(1)) begin
							idx_q <= '0;
						end else begin
							idx_q <= CW'(1);
						end
					end
				end
				bse_pkg::ST_SORT_RD: begin
					jdx_q <= idx_q;
				end
				bse_pkg::ST_SORT_CMP: begin
					if (after) begin
						jdx_q <= jdx_m1;
					end
				end
				bse_pkg::ST_SORT_PUT: begin
					idx_q <= set_last ? '0 : idx_inc;
				end
				bse_pkg::ST_EMIT_WAIT: begin
					if (out_ready) begin
						if (set_last) begin
							idx_q   <= '0;
							count_q <= '0;
							min_q   <= bse_pkg::VAL_MOST_POS;
							max_q   <= bse_pkg::VAL_MOST_NEG;
						end else begin
							idx_q <= idx_inc;
						end
					end
				end
				default: begin
					idx_q <= idx_q;
				end
			endcase
		end
	end

	// checks
	`BSE_ASSERT_NOW(a_no_overlap, out_valid, !in_ready, "input taken while a result is pending")
	`BSE_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(MAX_ITEMS), "item count beyond store depth")
	`BSE_ASSERT_NOW(a_tag_done_state, tag_rsp.done, state_q == bse_pkg::ST_TAG_DIV,
		"tag unit finished outside the tagging state")
	`BSE_ASSERT_NEXT(a_set_cleared, out_valid && out_ready && out_data.last_out,
		count_q == '0 && state_q == bse_pkg::ST_IDLE, "set not cleared after final beat")

endmodule

`default_nettype wire

### sim/bucket_sort_engine_core_tb.sv
// self-checking testbench for bucket_sort_engine_core: sets of q16.16 samples in,
// sorted beats out, compared against an in-bench bucket sort predictor
// depends on bse_pkg and the bucket_sort_engine_core rtl
`default_nettype none

module bucket_sort_engine_core_tb;

	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES   = 2000;

	// tracks the open set, predicts its sorted order and checks output beats
	class sort_scoreboard;
		longint            held[$];
		longint            lo_seen;
		longint            hi_seen;
		int                nb_reg;
		bse_pkg::bse_out_t expected_beats[$];
		int unsigned       errors;

		function new();
			nb_reg = int'(bse_pkg::BUCKET_COUNT_RST);
			errors = 0;
			clear_set();
		endfunction

		function void clear_set();
			held.delete();
			lo_seen = 64'sd2147483647;
			hi_seen = -64'sd2147483648;
		endfunction

		function void set_buckets(logic [bse_pkg::NB_W-1:0] v);
			nb_reg = int'(v);
		endfunction

		// zero means one bucket, anything above the maximum saturates
		function int active_buckets();
			int nb;
			nb = nb_reg;
			if (nb == 0) nb = 1;
			if (nb > bse_pkg::MAX_BUCKETS_DEF) nb = bse_pkg::MAX_BUCKETS_DEF;
			return nb;
		endfunction

		// floor(diff * nb / range) - 1, clamped to [0, nb-1]
		function int bucket_of_value(longint v, int nb);
			longint span;
			longint diff;
			longint nbl;
			longint q;
			if (hi_seen <= lo_seen) return 0;
			span = hi_seen - lo_seen;
			diff = v - lo_seen;
			nbl = nb;
			q = (diff * nbl) / span;
			if (q > 0) q = q - 1;
			if (q >= nbl) q = nbl - 1;
			return int'(q);
		endfunction

		// note an accepted input beat; a last beat releases the sorted set
		function void take_sample(bse_pkg::bse_in_t beat);
			longint            v;
			longint            vals[bse_pkg::MAX_ITEMS_DEF];
			int                tags[bse_pkg::MAX_ITEMS_DEF];
			longint            kv;
			int                kt;
			int                n;
			int                nb;
			int                j;
			bse_pkg::bse_out_t res;
			v = longint'($signed(beat.sample));
			if (held.size() < bse_pkg::MAX_ITEMS_DEF) begin
				held.push_back(v);
				if (v < lo_seen) lo_seen = v;
				if (v > hi_seen) hi_seen = v;
			end
			if (!beat.is_last) return;
			n = held.size();
			nb = active_buckets();
			for (int i = 0; i < n; i++) begin
				vals[i] = held[i];
				tags[i] = bucket_of_value(held[i], nb);
			end
			// insertion by bucket, then by value
			for (int i = 1; i < n; i++) begin
				kv = vals[i];
				kt = tags[i];
				j = i;
				while (j > 0 && (tags[j-1] > kt || (tags[j-1] == kt && vals[j-1] > kv))) begin
					vals[j] = vals[j-1];
					tags[j] = tags[j-1];
					j--;
				end
				vals[j] = kv;
				tags[j] = kt;
			end
			for (int i = 0; i < n; i++) begin
				res.sorted_value = vals[i][bse_pkg::VAL_W-1:0];
				res.last_out = (i == n - 1);
				expected_beats.push_back(res);
			end
			clear_set();
		endfunction

		// compare one output beat with the oldest expected one
		function void check_beat(bse_pkg::bse_out_t got);
			bse_pkg::bse_out_t exp_beat;
			if (expected_beats.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected output beat: value %0d last %0b",
						got.sorted_value, got.last_out);
				return;
			end
			exp_beat = expected_beats.pop_front();
			if (got.sorted_value !== exp_beat.sorted_value || got.last_out !== exp_beat.last_out) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected value %0d last %0b, got value %0d last %0b",
						exp_beat.sorted_value, exp_beat.last_out,
						got.sorted_value, got.last_out);
			end
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	bse_pkg::bse_in_t         in_data = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	bse_pkg::bse_out_t        out_data;
	logic                     cfg_we = 1'b0;
	logic [bse_pkg::NB_W-1:0] cfg_wdata = '0;

	sort_scoreboard sb;
	bit             tx_calm = 1'b0;
	int             rx_hold = 0;

	bucket_sort_engine_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #1 clk = ~clk;

	// run limit
	initial begin
		#2000000;
		$display("bucket_sort_engine_core_tb: done, errors");
		$finish;
	end

	// offer one sample beat after a random gap and wait for it to be taken
	task automatic send_beat(input logic signed [bse_pkg::VAL_W-1:0] v, input logic last);
		int               gap;
		bse_pkg::bse_in_t beat;
		gap = tx_calm ? 0 : $urandom_range(0, 11);
		beat.sample = v;
		beat.is_last = last;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= beat;
		do @(posedge clk); while (!in_ready);
		sb.take_sample(beat);
	endtask

	// stop offering and wait until every expected beat is out
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.expected_beats.size() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// bucket count write, only while the block is idle
	task automatic write_buckets(input logic [bse_pkg::NB_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		sb.set_buckets(v);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [bse_pkg::VAL_W-1:0] draw_sample(int mode,
		logic signed [bse_pkg::VAL_W-1:0] base);
		logic signed [bse_pkg::VAL_W-1:0] v;
		case (mode)
			0: v = $urandom();
			1: v = base + $urandom_range(0, 255);
			2: v = base + ($urandom_range(0, 3) << 16);
			default: begin
				case ($urandom_range(0, 4))
					0: v = bse_pkg::VAL_MOST_NEG;
					1: v = bse_pkg::VAL_MOST_POS;
					2: v = '0;
					3: v = -1;
					default: v = $urandom();
				endcase
			end
		endcase
		return v;
	endfunction

	// one set of n samples, the last one flagged
	task automatic send_set(input int n);
		int                               mode;
		logic signed [bse_pkg::VAL_W-1:0] base;
		mode = $urandom_range(0, 3);
		base = $urandom();
		tx_calm = ($urandom_range(0, 4) == 0);
		for (int i = 0; i < n; i++)
			send_beat(draw_sample(mode, base), i == n - 1);
		tx_calm = 1'b0;
	endtask

	// one bucket count setting with random sets
	task automatic run_phase(input logic [bse_pkg::NB_W-1:0] nb, input int budget,
		input int big_set, input bit with_hold);
		int sent;
		int r;
		int n;
		write_buckets(nb);
		sent = 0;
		if (big_set > 0) begin
			send_set(big_set);
			sent += big_set;
		end
		if (with_hold) begin
			// receiver stalls while the sender keeps pushing the next sets
			rx_hold = HOLD_CYCLES;
			send_set(20);
			sent += 20;
		end
		while (sent < budget) begin
			r = $urandom_range(0, 9);
			if (r < 6) n = $urandom_range(1, 8);
			else if (r < 9) n = $urandom_range(9, 24);
			else n = $urandom_range(25, bse_pkg::MAX_ITEMS_DEF);
			send_set(n);
			sent += n;
		end
		settle();
	endtask

	// output side: random stalls, one long hold on request
	initial begin : rx_side
		int stall;
		bit calm;
		calm = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 15) == 0) calm = ~calm;
			stall = calm ? 0 : $urandom_range(0, 11);
			if (rx_hold > 0) begin
				stall = rx_hold;
				rx_hold = 0;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			sb.check_beat(out_data);
		end
	end

	// main sequence
	initial begin
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed sets under the reset bucket count
		send_beat('0, 1'b1);
		send_beat(bse_pkg::VAL_MOST_POS, 1'b0);
		send_beat(bse_pkg::VAL_MOST_NEG, 1'b0);
		send_beat('0, 1'b0);
		send_beat(-1, 1'b0);
		send_beat(32'sh0000_0001, 1'b0);
		send_beat(32'sh0001_0000, 1'b1);
		// equal extremes
		send_beat(32'sh0003_8000, 1'b0);
		send_beat(32'sh0003_8000, 1'b0);
		send_beat(32'sh0003_8000, 1'b1);
		send_beat(-1, 1'b0);
		send_beat(bse_pkg::VAL_MOST_NEG, 1'b1);
		// duplicates on both sides of zero
		send_beat(32'sh0007_0000, 1'b0);
		send_beat(-32'sh0003_0000, 1'b0);
		send_beat(32'sh0007_0000, 1'b0);
		send_beat(-32'sh0003_0000, 1'b1);
		// descending order
		send_beat(32'sh0028_0000, 1'b0);
		send_beat(32'sh001e_0000, 1'b0);
		send_beat(32'sh0014_0000, 1'b0);
		send_beat(32'sh000a_0000, 1'b0);
		send_beat('0, 1'b1);
		settle();

		// random sets over a sweep of bucket counts
		run_phase(bse_pkg::NB_W'(1), 44, 0, 1'b0);
		run_phase(bse_pkg::NB_W'(bse_pkg::MAX_BUCKETS_DEF), 44, bse_pkg::MAX_ITEMS_DEF, 1'b0);
		run_phase(bse_pkg::NB_W'(0), 44, 0, 1'b0);
		// store overflow: extra samples dropped, the last flag still sorts
		run_phase({bse_pkg::NB_W{1'b1}}, 44, bse_pkg::MAX_ITEMS_DEF + 6, 1'b0);
		run_phase(bse_pkg::NB_W'($urandom_range(2, 63)), 44, 0, 1'b1);
		run_phase(bse_pkg::NB_W'($urandom_range(2, 63)), 44, 0, 1'b0);

		settle();
		if (sb.expected_beats.size() > 0)
			$display("%0d expected beats never arrived", sb.expected_beats.size());
		if (sb.errors == 0 && sb.expected_beats.size() == 0) begin
			$display("bucket_sort_engine_core_tb: done, clean");
		end else begin
			$display("bucket_sort_engine_core_tb: done, errors");
		end
		$finish;
	end

endmodule

`default_nettype wire

### bucket_sort_engine_core.f
+incdir+src
src/bse_pkg.sv
src/bse_tag_unit.sv
src/bucket_sort_engine_core.sv
sim/bucket_sort_engine_core_tb.sv
